// File: design/suv_pkg.sv
// ----------------------------------------------------------------------------
// suv_pkg
// Types and constants shared by the strict UTF-8 validator files.
// ----------------------------------------------------------------------------
package suv_pkg;

   // allowed range for the second byte of a multi-byte sequence
   typedef enum logic [2:0] {
      CLS_ANY  = 3'd0,   // 80..BF
      CLS_A0BF = 3'd1,   // after E0, rules out overlong three-byte forms
      CLS_809F = 3'd2,   // after ED, rules out surrogates
      CLS_90BF = 3'd3,   // after F0, rules out overlong four-byte forms
      CLS_808F = 3'd4    // after F4, caps code points at 10FFFF
   } second_class_type;

   // per-string scan state
   typedef struct packed {
      logic [1:0]       pending;
      second_class_type cls;
      logic             error;
   } scan_state_type;

   localparam scan_state_type SCAN_IDLE = '{pending: 2'd0, cls: CLS_ANY, error: 1'b0};
   localparam scan_state_type SCAN_FAIL = '{pending: 2'd0, cls: CLS_ANY, error: 1'b1};

   // continuation byte tag and range limits
   localparam logic [1:0] CONT_TAG  = 2'b10;
   localparam logic [7:0] CONT_A0   = 8'hA0;
   localparam logic [7:0] CONT_9F   = 8'h9F;
   localparam logic [7:0] CONT_90   = 8'h90;
   localparam logic [7:0] CONT_8F   = 8'h8F;

endpackage

// File: design/suv_channels.sv
// ----------------------------------------------------------------------------
// suv channels
// Valid/ready channels for input bytes and for verdicts.
// ----------------------------------------------------------------------------
interface suv_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       has_byte;
   logic       last_byte;

   modport source (output valid, output data_byte, output has_byte, output last_byte,
                   input ready);
   modport sink   (input valid, input data_byte, input has_byte, input last_byte,
                   output ready);
endinterface

interface suv_rsp_if;
   logic valid;
   logic ready;
   logic string_ok;

   modport source (output valid, output string_ok, input ready);
   modport sink   (input valid, input string_ok, output ready);
endinterface

// File: design/suv_step.sv
// ----------------------------------------------------------------------------
// suv_step
// Next scan state for one byte: lead byte decode and continuation checks.
// ----------------------------------------------------------------------------
module suv_step
   import suv_pkg::*;
(
   input  scan_state_type cur_state,
   input  logic [7:0]     data_byte,
   input  logic           has_byte,
   output scan_state_type nxt_state
);

   logic is_cont;
   logic cont_ok;

   // continuation byte inside the range allowed by the class
   assign is_cont = (data_byte[7:6] == CONT_TAG);

   always_comb begin
      case (cur_state.cls)
         CLS_A0BF: cont_ok = is_cont && (data_byte >= CONT_A0);
         CLS_809F: cont_ok = is_cont && (data_byte <= CONT_9F);
         CLS_90BF: cont_ok = is_cont && (data_byte >= CONT_90);
         CLS_808F: cont_ok = is_cont && (data_byte <= CONT_8F);
         default:  cont_ok = is_cont;
      endcase
   end

   // state update
   always_comb begin
      nxt_state = cur_state;
      if (has_byte) begin
         if (cur_state.pending != 2'd0) begin
            if (cont_ok) begin
               nxt_state.pending = cur_state.pending - 2'd1;
               nxt_state.cls     = CLS_ANY;
            end else begin
               nxt_state = SCAN_FAIL;
            end
         end else begin
            case (data_byte) inside
               8'h00:          nxt_state = SCAN_FAIL;
               [8'h01:8'h7F]:  nxt_state = cur_state;
               [8'hC2:8'hDF]:  nxt_state = '{pending: 2'd1, cls: CLS_ANY,  error: cur_state.error};
               8'hE0:          nxt_state = '{pending: 2'd2, cls: CLS_A0BF, error: cur_state.error};
               8'hED:          nxt_state = '{pending: 2'd2, cls: CLS_809F, error: cur_state.error};
               [8'hE1:8'hEF]:  nxt_state = '{pending: 2'd2, cls: CLS_ANY,  error: cur_state.error};
               8'hF0:          nxt_state = '{pending: 2'd3, cls: CLS_90BF, error: cur_state.error};
               [8'hF1:8'hF3]:  nxt_state = '{pending: 2'd3, cls: CLS_ANY,  error: cur_state.error};
               8'hF4:          nxt_state = '{pending: 2'd3, cls: CLS_808F, error: cur_state.error};
               // stray continuation, C0, C1, F5..FF
               default:        nxt_state = SCAN_FAIL;
            endcase
         end
      end
   end

endmodule

// File: design/strict_utf8_validator_top.sv
// ----------------------------------------------------------------------------
// strict_utf8_validator_top
// Strict UTF-8 check of a byte string, one byte per word, verdict at the end.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries one byte per word (data_byte, has_byte) and marks the
//   end of a string with last_byte. A word with has_byte low adds no byte;
//   with last_byte high it closes the string (an empty string passes).
//   rsp_chan gives one word per string: string_ok is high when the string
//   was strict UTF-8 with no NUL byte, no overlong form, no surrogate, no
//   code point above 10FFFF and no truncated sequence.
// Timing:
//   one word accepted every cycle while req_chan.ready is high; the verdict
//   comes from the closing word via the input register, then the result register.
//   The scan state is one small register updated once per byte.
// Reset:
//   synchronous reset empties both registers and clears the scan state;
//   req_chan.ready stays low while reset is high.
// Stall:
//   while a verdict waits on rsp_chan.ready, bytes of the next string still
//   flow in; only a second closing word waits in the input register, and
//   req_chan.ready drops once that register cannot move.
// ----------------------------------------------------------------------------
module strict_utf8_validator_top
   import suv_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   suv_req_if.sink         req_chan,
   suv_rsp_if.source       rsp_chan
);

   // input register
   logic           in_valid_ff, in_valid_in;
   logic [7:0]     in_byte_ff;
   logic           in_has_ff;
   logic           in_last_ff;

   // scan state and result register
   scan_state_type state_ff, state_in;
   scan_state_type step_state;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           rsp_ok_ff, rsp_ok_in;

   logic           req_take;
   logic           out_free;
   logic           in_go;

   // handshake
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;
   assign in_go          = in_valid_ff && (!in_last_ff || out_free);
   assign req_chan.ready = !reset && (!in_valid_ff || in_go);
   assign req_take       = req_chan.valid && req_chan.ready;

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.string_ok = rsp_ok_ff;

   // byte check
   suv_step u_step (
      .cur_state (state_ff),
      .data_byte (in_byte_ff),
      .has_byte  (in_has_ff),
      .nxt_state (step_state)
   );

   // next values
   always_comb begin
      in_valid_in  = req_take ? 1'b1 : (in_go ? 1'b0 : in_valid_ff);
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_ok_in    = rsp_ok_ff;
      if (in_go) begin
         if (in_last_ff) begin
            state_in     = SCAN_IDLE;
            rsp_valid_in = 1'b1;
            rsp_ok_in    = !step_state.error && (step_state.pending == 2'd0);
         end else begin
            state_in = step_state;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= SCAN_IDLE;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         state_ff     <= state_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_chan.data_byte;
         in_has_ff  <= req_chan.has_byte;
         in_last_ff <= req_chan.last_byte;
      end
      rsp_ok_ff <= rsp_ok_in;
   end

   // checks
   a_clear_after_verdict: assert property (@(posedge clock) disable iff (reset)
      (in_go && in_last_ff) |=> (state_ff == SCAN_IDLE))
      else $error("scan state not cleared after verdict");

   a_verdict_held: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_chan.ready) |=> (rsp_valid_ff && $stable(rsp_ok_ff)))
      else $error("waiting verdict changed or dropped");

   a_class_needs_pending: assert property (@(posedge clock) disable iff (reset)
      (state_ff.cls != CLS_ANY) |-> (state_ff.pending >= 2'd2))
      else $error("second byte class without a fresh lead byte");

   a_verdict_only_on_last: assert property (@(posedge clock) disable iff (reset)
      (!(in_go && in_last_ff) && !(rsp_valid_ff && !rsp_chan.ready)) |=> !rsp_valid_ff)
      else $error("verdict without closing word");

endmodule
